/* design/ppc_pkg.sv */
// ppc_pkg: shared types, codes and constant tables of the packet protocol classifier.
// No dependencies; every other design file refers to it by scoped names.
`timescale 1ns / 1ps

package ppc_pkg;

    localparam int PREFIX_BYTES = 7;
    localparam int METHOD_COUNT = 9;
    localparam int PORT_W       = 16;
    localparam int CFG_IDX_W    = 8;

    typedef logic [7:0]        t_byte;
    typedef logic [PORT_W-1:0] t_port;

    // Payload prefix, element 0 is the first payload byte
    typedef logic [PREFIX_BYTES-1:0][7:0] t_prefix;

    // IP transport numbers
    localparam t_byte XPORT_TCP = 8'd6;
    localparam t_byte XPORT_UDP = 8'd17;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IM_UDP_PORT      = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HTTP_TCP_PORT    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FTP_DATA_PORT    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FTP_CONTROL_PORT = 8'd3;

    // Register reset values
    localparam t_port RST_IM_UDP_PORT      = 16'd8000;
    localparam t_port RST_HTTP_TCP_PORT    = 16'd80;
    localparam t_port RST_FTP_DATA_PORT    = 16'd20;
    localparam t_port RST_FTP_CONTROL_PORT = 16'd21;

    typedef enum logic [1:0] {
        CLS_UNKNOWN = 2'd0,
        CLS_IM      = 2'd1,
        CLS_HTTP    = 2'd2,
        CLS_FTP     = 2'd3
    } t_proto_code;

    typedef enum logic {
        DIR_REQ = 1'b0,
        DIR_RSP = 1'b1
    } t_dir;

    typedef struct packed {
        t_port im_udp_port;
        t_port http_tcp_port;
        t_port ftp_data_port;
        t_port ftp_control_port;
    } t_cfg;

    typedef struct packed {
        t_byte transport_proto;
        t_port src_port;
        t_port dst_port;
        logic [15:0] payload_length;
        t_byte byte_zero;
        t_byte byte_one;
        t_byte byte_two;
        t_byte byte_three;
        t_byte byte_four;
        t_byte byte_five;
        t_byte byte_six;
    } t_in_item;

    typedef struct packed {
        t_proto_code proto_code;
        t_dir        direction;
    } t_out_item;

    // Lower-case ASCII letters used by the prefix words
    localparam t_byte CH_A = 8'h61;
    localparam t_byte CH_C = 8'h63;
    localparam t_byte CH_D = 8'h64;
    localparam t_byte CH_E = 8'h65;
    localparam t_byte CH_G = 8'h67;
    localparam t_byte CH_H = 8'h68;
    localparam t_byte CH_I = 8'h69;
    localparam t_byte CH_L = 8'h6C;
    localparam t_byte CH_N = 8'h6E;
    localparam t_byte CH_O = 8'h6F;
    localparam t_byte CH_P = 8'h70;
    localparam t_byte CH_R = 8'h72;
    localparam t_byte CH_S = 8'h73;
    localparam t_byte CH_T = 8'h74;
    localparam t_byte CH_U = 8'h75;
    localparam t_byte CH_NUL = 8'h00;

    // A prefix word: letters (element 0 first) and its length
    typedef struct packed {
        logic [2:0] len;
        t_prefix    ch;
    } t_word;

    localparam t_word METHOD_WORDS [METHOD_COUNT] = '{
        '{len: 3'd3, ch: {CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_T, CH_E, CH_G}},
        '{len: 3'd4, ch: {CH_NUL, CH_NUL, CH_NUL, CH_T, CH_S, CH_O, CH_P}},
        '{len: 3'd4, ch: {CH_NUL, CH_NUL, CH_NUL, CH_D, CH_A, CH_E, CH_H}},
        '{len: 3'd3, ch: {CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_T, CH_U, CH_P}},
        '{len: 3'd6, ch: {CH_NUL, CH_E, CH_T, CH_E, CH_L, CH_E, CH_D}},
        '{len: 3'd7, ch: {CH_T, CH_C, CH_E, CH_N, CH_N, CH_O, CH_C}},
        '{len: 3'd7, ch: {CH_S, CH_N, CH_O, CH_I, CH_T, CH_P, CH_O}},
        '{len: 3'd5, ch: {CH_NUL, CH_NUL, CH_E, CH_C, CH_A, CH_R, CH_T}},
        '{len: 3'd5, ch: {CH_NUL, CH_NUL, CH_H, CH_C, CH_T, CH_A, CH_P}}
    };

    localparam t_word REPLY_WORD =
        '{len: 3'd4, ch: {CH_NUL, CH_NUL, CH_NUL, CH_P, CH_T, CH_T, CH_H}};

    // Only A..Z fold
    function automatic t_byte fold_lower(input t_byte b);
        t_byte r;
        r = b;
        if (b >= 8'h41 && b <= 8'h5A) begin
            r = b + 8'h20;
        end
        return r;
    endfunction

    // Word hit: every letter position present in the payload and equal
    function automatic logic match_word(input t_prefix b, input logic [PREFIX_BYTES-1:0] v,
                                        input t_word w);
        logic hit;
        hit = 1'b1;
        for (int i = 0; i < PREFIX_BYTES; i++) begin
            if (3'(i) < w.len) begin
                hit = hit & v[i] & (b[i] == w.ch[i]);
            end
        end
        return hit;
    endfunction

endpackage

/* design/ppc_in_if.sv */
// ppc_in_if: input channel of the classifier, one packet descriptor per transfer.
// Depends on ppc_pkg for the payload type.
`timescale 1ns / 1ps

interface ppc_in_if;
    logic               valid;
    logic               ready;
    ppc_pkg::t_in_item  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* design/ppc_out_if.sv */
// ppc_out_if: result channel of the classifier, protocol code and direction per transfer.
// Depends on ppc_pkg for the payload type.
`timescale 1ns / 1ps

interface ppc_out_if;
    logic               valid;
    logic               ready;
    ppc_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* design/ppc_cfg_regs.sv */
// ppc_cfg_regs: the four port registers and their write decode.
// Depends on ppc_pkg.
`timescale 1ns / 1ps

module ppc_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_we,
    input  logic [ppc_pkg::CFG_IDX_W-1:0]   i_idx,
    input  ppc_pkg::t_port                  i_data,
    output ppc_pkg::t_cfg                   o_cfg
);

    ppc_pkg::t_cfg r_cfg;
    ppc_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_we) begin
            case (i_idx)
                ppc_pkg::CFG_IM_UDP_PORT:      n_cfg.im_udp_port      = i_data;
                ppc_pkg::CFG_HTTP_TCP_PORT:    n_cfg.http_tcp_port    = i_data;
                ppc_pkg::CFG_FTP_DATA_PORT:    n_cfg.ftp_data_port    = i_data;
                ppc_pkg::CFG_FTP_CONTROL_PORT: n_cfg.ftp_control_port = i_data;
                default: ; // unused index, ignored
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.im_udp_port      <= ppc_pkg::RST_IM_UDP_PORT;
            r_cfg.http_tcp_port    <= ppc_pkg::RST_HTTP_TCP_PORT;
            r_cfg.ftp_data_port    <= ppc_pkg::RST_FTP_DATA_PORT;
            r_cfg.ftp_control_port <= ppc_pkg::RST_FTP_CONTROL_PORT;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* design/ppc_classify.sv */
// ppc_classify: combinational priority classification of one packet descriptor.
// Depends on ppc_pkg (word table, fold and match functions).
`timescale 1ns / 1ps

module ppc_classify (
    input  ppc_pkg::t_in_item  i_item,
    input  ppc_pkg::t_cfg      i_cfg,
    output ppc_pkg::t_out_item o_res
);

    ppc_pkg::t_prefix                    raw;
    ppc_pkg::t_prefix                    folded;
    logic [ppc_pkg::PREFIX_BYTES-1:0]    present;
    logic                                is_tcp;
    logic                                is_udp;
    logic                                method_hit;
    logic                                reply_hit;
    logic                                ftp_dst;
    logic                                ftp_src;

    assign raw = {i_item.byte_six, i_item.byte_five, i_item.byte_four, i_item.byte_three,
                  i_item.byte_two, i_item.byte_one, i_item.byte_zero};

    always_comb begin
        for (int i = 0; i < ppc_pkg::PREFIX_BYTES; i++) begin
            folded[i]  = ppc_pkg::fold_lower(raw[i]);
            present[i] = (i_item.payload_length > 16'(i));
        end
    end

    always_comb begin
        method_hit = 1'b0;
        for (int k = 0; k < ppc_pkg::METHOD_COUNT; k++) begin
            method_hit = method_hit |
                         ppc_pkg::match_word(folded, present, ppc_pkg::METHOD_WORDS[k]);
        end
    end

    assign reply_hit = ppc_pkg::match_word(folded, present, ppc_pkg::REPLY_WORD);
    assign is_tcp    = (i_item.transport_proto == ppc_pkg::XPORT_TCP);
    assign is_udp    = (i_item.transport_proto == ppc_pkg::XPORT_UDP);
    assign ftp_dst   = (i_item.dst_port == i_cfg.ftp_data_port) ||
                       (i_item.dst_port == i_cfg.ftp_control_port);
    assign ftp_src   = (i_item.src_port == i_cfg.ftp_data_port) ||
                       (i_item.src_port == i_cfg.ftp_control_port);

    always_comb begin
        o_res.proto_code = ppc_pkg::CLS_UNKNOWN;
        o_res.direction  = ppc_pkg::DIR_REQ;
        if (is_udp) begin
            if (i_item.dst_port == i_cfg.im_udp_port) begin
                o_res.proto_code = ppc_pkg::CLS_IM;
            end else if (i_item.src_port == i_cfg.im_udp_port) begin
                o_res.proto_code = ppc_pkg::CLS_IM;
                o_res.direction  = ppc_pkg::DIR_RSP;
            end
        end else if (is_tcp) begin
            if (i_item.dst_port == i_cfg.http_tcp_port) begin
                o_res.proto_code = ppc_pkg::CLS_HTTP;
            end else if (i_item.src_port == i_cfg.http_tcp_port) begin
                o_res.proto_code = ppc_pkg::CLS_HTTP;
                o_res.direction  = ppc_pkg::DIR_RSP;
            end else if (method_hit) begin
                o_res.proto_code = ppc_pkg::CLS_HTTP;
            end else if (reply_hit) begin
                o_res.proto_code = ppc_pkg::CLS_HTTP;
                o_res.direction  = ppc_pkg::DIR_RSP;
            end else if (ftp_dst) begin
                o_res.proto_code = ppc_pkg::CLS_FTP;
            end else if (ftp_src) begin
                o_res.proto_code = ppc_pkg::CLS_FTP;
                o_res.direction  = ppc_pkg::DIR_RSP;
            end
        end
    end

endmodule

/* design/packet_protocol_classifier.sv */
// packet_protocol_classifier: top level, input register, classifier and result register.
// Depends on ppc_pkg, ppc_in_if, ppc_out_if, ppc_cfg_regs and ppc_classify.
`timescale 1ns / 1ps

// One packet descriptor per transfer in, one result per transfer out, in order.
// Each packet passes the input register, then the result register. Throughput is one
// packet per cycle while results are taken, since the only logic between the input
// and result registers is a row of port compares and seven-byte prefix matches.
// Both stages advance whenever the stage ahead is empty or being drained, so
// input ready stays high while a finished result waits only as long as the
// input register is empty; with both registers full and the result not taken,
// the input stalls. Port registers (im UDP, HTTP TCP, two FTP TCP) reset to
// 8000, 80, 20 and 21 and are written through the plain write port; writes to
// an index of 4 or above are dropped. Write them only with the block empty.
module packet_protocol_classifier (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    ppc_in_if.sink                         i_in,
    ppc_out_if.source                      o_out,
    input  logic                           i_cfg_we,
    input  logic [ppc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  ppc_pkg::t_port                 i_cfg_data
);

    ppc_pkg::t_cfg      cfg;
    ppc_pkg::t_out_item cls_res;

    // input stage
    logic               r_s1_valid;
    logic               n_s1_valid;
    ppc_pkg::t_in_item  r_s1_item;

    // result stage
    logic               r_out_valid;
    logic               n_out_valid;
    ppc_pkg::t_out_item r_out_item;

    logic               out_adv;
    logic               s1_adv;

    ppc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    ppc_classify u_cls (
        .i_item (r_s1_item),
        .i_cfg  (cfg),
        .o_res  (cls_res)
    );

    // result register free, or its transfer happens this cycle
    assign out_adv = !r_out_valid || o_out.ready;
    // input register free, or it moves into the result register
    assign s1_adv  = !r_s1_valid || out_adv;

    assign i_in.ready = s1_adv;

    always_comb begin
        n_s1_valid  = r_s1_valid;
        n_out_valid = r_out_valid;
        if (s1_adv) begin
            n_s1_valid = i_in.valid;
        end
        if (out_adv) begin
            n_out_valid = r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (s1_adv && i_in.valid) begin
            r_s1_item <= i_in.data;
        end
        if (out_adv && r_s1_valid) begin
            r_out_item <= cls_res;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_item;

    // ---- checks ----

    // nothing offered in the cycle after reset
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_out.valid)
        else $error("result valid right after reset");

    // a packet in the input register that moves on shows as a result next cycle
    a_stage_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && out_adv) |=> o_out.valid)
        else $error("input stage advanced but no result appeared");

    // an empty result register never holds back the input
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_in.ready)
        else $error("input stalled with result register empty");

    // unknown traffic always reports the request direction
    a_unknown_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.data.proto_code != ppc_pkg::CLS_UNKNOWN ||
                         o_out.data.direction == ppc_pkg::DIR_REQ))
        else $error("unknown protocol with response direction");

endmodule
